>>> sv/multi_stack_transfer_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-stack transfer engine
// Shared property wrappers, clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_STACK_TRANSFER_ENGINE_ASSERT_SVH
`define MULTI_STACK_TRANSFER_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSTE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MSTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/mste_pkg.sv
// ----------------------------------------------------------------------------
// mste_pkg
// Constants, types and helpers shared by the transfer engine modules.
// ----------------------------------------------------------------------------
package mste_pkg;

    localparam int NUM_STACKS  = 16;
    localparam int STACK_DEPTH = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int OP_W     = 2;
    localparam int CNT_W    = 7;
    localparam int IDX_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;

    localparam int SID_W     = $clog2(NUM_STACKS);
    localparam int POS_W     = $clog2(STACK_DEPTH);
    localparam int HGT_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W    = SID_W + POS_W;
    localparam int MEM_DEPTH = NUM_STACKS * (2 ** POS_W);
    localparam int QP_W      = $clog2(QUEUE_DEPTH);
    localparam int QC_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CW        = (HGT_W > CNT_W) ? HGT_W : CNT_W;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [OP_W-1:0] OP_PUSH     = 2'd0;
    localparam logic [OP_W-1:0] OP_MOVE_REV = 2'd1;
    localparam logic [OP_W-1:0] OP_MOVE_BLK = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SRC_CLAMP = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DST_CLAMP = 2'd2;

    typedef enum logic [1:0] {
        KIND_PUSH,
        KIND_MOVE_REV,
        KIND_MOVE_BLK,
        KIND_HOLD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CNT_W-1:0]  count;
        logic [SID_W-1:0]  src;
        logic [SID_W-1:0]  dst;
        logic [BYTE_W-1:0] item;
    } cmd_t;

    // Declared from the top bit down, so moved lands in the lowest bits.
    typedef struct packed {
        logic                dst_empty;
        logic [BYTE_W-1:0]   dst_top;
        logic                src_empty;
        logic [BYTE_W-1:0]   src_top;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    moved;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_HS,
        ST_RD_HD,
        ST_PLAN,
        ST_COPY,
        ST_WR_HS,
        ST_WR_HD,
        ST_TOP_S,
        ST_TOP_D,
        ST_DONE
    } state_t;

    // Reduces a stack index field modulo NUM_STACKS by repeated subtraction.
    function automatic logic [SID_W-1:0] stack_index(input logic [IDX_W-1:0] f);
        logic [7:0] r;
        r = 8'(f);
        for (int k = 0; k < 8; k++) begin
            if (r >= 8'(NUM_STACKS)) begin
                r = r - 8'(NUM_STACKS);
            end
        end
        return SID_W'(r);
    endfunction

endpackage

>>> sv/mste_front.sv
// ----------------------------------------------------------------------------
// mste_front
// Accepts requests, classifies them and holds them in a short command queue.
// ----------------------------------------------------------------------------
module mste_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mste_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [mste_pkg::OP_W-1:0]       s_tuser,
    output logic                            q_valid,
    output mste_pkg::cmd_t                  q_cmd,
    input  logic                            q_pop
);

    mste_pkg::cmd_t                  queue_reg [mste_pkg::QUEUE_DEPTH];
    logic [mste_pkg::QP_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [mste_pkg::QP_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [mste_pkg::QC_W-1:0]       fill_reg, fill_next;
    mste_pkg::cmd_t                  dec_cmd;
    logic [mste_pkg::SID_W-1:0]      src_idx, dst_idx;
    logic                            push_en;

    // Field unpack and classification.
    always_comb begin
        src_idx = mste_pkg::stack_index(s_tdata[10:7]);
        dst_idx = mste_pkg::stack_index(s_tdata[14:11]);
        dec_cmd.count = s_tdata[6:0];
        dec_cmd.src   = src_idx;
        dec_cmd.dst   = dst_idx;
        dec_cmd.item  = s_tdata[22:15];
        unique case (s_tuser)
            mste_pkg::OP_PUSH: begin
                dec_cmd.kind = mste_pkg::KIND_PUSH;
                dec_cmd.dst  = src_idx;
            end
            mste_pkg::OP_MOVE_REV: begin
                dec_cmd.kind = (src_idx != dst_idx) ? mste_pkg::KIND_MOVE_REV
                                                    : mste_pkg::KIND_HOLD;
            end
            mste_pkg::OP_MOVE_BLK: begin
                dec_cmd.kind = (src_idx != dst_idx) ? mste_pkg::KIND_MOVE_BLK
                                                    : mste_pkg::KIND_HOLD;
            end
            default: begin
                dec_cmd.kind = mste_pkg::KIND_HOLD;
            end
        endcase
    end

    assign s_tready = (fill_reg != mste_pkg::QC_W'(mste_pkg::QUEUE_DEPTH));
    assign push_en  = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != '0);
    assign q_cmd    = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push_en) begin
            wr_ptr_next = (wr_ptr_reg == mste_pkg::QP_W'(mste_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + mste_pkg::QP_W'(1);
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == mste_pkg::QP_W'(mste_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + mste_pkg::QP_W'(1);
        end
        if (push_en && !q_pop) begin
            fill_next = fill_reg + mste_pkg::QC_W'(1);
        end else if (!push_en && q_pop) begin
            fill_next = fill_reg - mste_pkg::QC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            queue_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

endmodule

>>> sv/mste_back.sv
// ----------------------------------------------------------------------------
// mste_back
// Executes queued commands against the stack store and height registers.
// ----------------------------------------------------------------------------
`include "multi_stack_transfer_engine_assert.svh"

module mste_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  mste_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output mste_pkg::result_t   m_result
);

    // Stack store: one write and one registered read per cycle.
    logic [mste_pkg::BYTE_W-1:0]   mem [mste_pkg::MEM_DEPTH];
    logic [mste_pkg::BYTE_W-1:0]   rd_data_reg;

    logic [mste_pkg::HGT_W-1:0]    height_reg [mste_pkg::NUM_STACKS];

    mste_pkg::state_t              state_reg, state_next;
    mste_pkg::cmd_t                cmd_reg;
    logic [mste_pkg::HGT_W-1:0]    hs_reg, hd_reg;
    logic [mste_pkg::HGT_W-1:0]    hs_new_reg, hd_new_reg;
    logic [mste_pkg::HGT_W-1:0]    n_reg, idx_reg;
    logic [mste_pkg::CNT_W-1:0]    moved_reg;
    logic [mste_pkg::STATUS_W-1:0] status_reg;
    logic [mste_pkg::BYTE_W-1:0]   src_top_reg;
    logic                          m_valid_reg;
    mste_pkg::result_t             result_reg;

    logic                          mem_we, mem_re;
    logic [mste_pkg::ADDR_W-1:0]   mem_wa, mem_ra;
    logic [mste_pkg::BYTE_W-1:0]   mem_wd;
    logic                          hgt_we;
    logic [mste_pkg::SID_W-1:0]    hgt_idx;
    logic [mste_pkg::HGT_W-1:0]    hgt_wdata, hgt_rdata;
    logic                          res_load;

    logic [mste_pkg::CW-1:0]       cnt_w, hs_w, room_w, n_w;
    logic [mste_pkg::STATUS_W-1:0] plan_status;
    logic [mste_pkg::HGT_W-1:0]    plan_n, from_pos, to_pos;
    logic                          push_fits;
    logic                          is_move;

    assign hgt_rdata = height_reg[hgt_idx];
    assign is_move   = (cmd_reg.kind == mste_pkg::KIND_MOVE_REV) ||
                       (cmd_reg.kind == mste_pkg::KIND_MOVE_BLK);
    assign push_fits = hs_reg < mste_pkg::HGT_W'(mste_pkg::STACK_DEPTH);

    // Count clamping: source height first, then destination free space.
    always_comb begin
        cnt_w  = mste_pkg::CW'(cmd_reg.count);
        hs_w   = mste_pkg::CW'(hs_reg);
        room_w = mste_pkg::CW'(mste_pkg::STACK_DEPTH) - mste_pkg::CW'(hd_reg);
        n_w    = cnt_w;
        plan_status = mste_pkg::STATUS_OK;
        if (n_w > hs_w) begin
            n_w = hs_w;
            plan_status = mste_pkg::STATUS_SRC_CLAMP;
        end
        if (n_w > room_w) begin
            n_w = room_w;
            plan_status = mste_pkg::STATUS_DST_CLAMP;
        end
        plan_n = mste_pkg::HGT_W'(n_w);
    end

    // Reverse mode walks down from the top; block mode walks up from hs - n.
    assign from_pos = (cmd_reg.kind == mste_pkg::KIND_MOVE_REV)
                      ? hs_reg - mste_pkg::HGT_W'(1) - idx_reg
                      : hs_reg - n_reg + idx_reg;
    assign to_pos   = hd_reg + idx_reg - mste_pkg::HGT_W'(1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mste_pkg::ST_IDLE:  if (q_valid) state_next = mste_pkg::ST_RD_HS;
            mste_pkg::ST_RD_HS: state_next = mste_pkg::ST_RD_HD;
            mste_pkg::ST_RD_HD: state_next = mste_pkg::ST_PLAN;
            mste_pkg::ST_PLAN: begin
                if (is_move && plan_n != '0) begin
                    state_next = mste_pkg::ST_COPY;
                end else begin
                    state_next = mste_pkg::ST_WR_HS;
                end
            end
            mste_pkg::ST_COPY:  if (idx_reg == n_reg) state_next = mste_pkg::ST_WR_HS;
            mste_pkg::ST_WR_HS: state_next = mste_pkg::ST_WR_HD;
            mste_pkg::ST_WR_HD: state_next = mste_pkg::ST_TOP_S;
            mste_pkg::ST_TOP_S: state_next = mste_pkg::ST_TOP_D;
            mste_pkg::ST_TOP_D: state_next = mste_pkg::ST_DONE;
            mste_pkg::ST_DONE:  if (res_load) state_next = mste_pkg::ST_IDLE;
            default:            state_next = mste_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wa    = {cmd_reg.dst, to_pos[mste_pkg::POS_W-1:0]};
        mem_ra    = {cmd_reg.src, from_pos[mste_pkg::POS_W-1:0]};
        mem_wd    = rd_data_reg;
        hgt_we    = 1'b0;
        hgt_idx   = cmd_reg.src;
        hgt_wdata = hs_new_reg;
        res_load  = 1'b0;
        unique case (state_reg)
            mste_pkg::ST_IDLE: begin
                q_pop = q_valid;
            end
            mste_pkg::ST_RD_HS: begin
                hgt_idx = cmd_reg.src;
            end
            mste_pkg::ST_RD_HD: begin
                hgt_idx = cmd_reg.dst;
            end
            mste_pkg::ST_PLAN: begin
                if (cmd_reg.kind == mste_pkg::KIND_PUSH && push_fits) begin
                    mem_we = 1'b1;
                    mem_wa = {cmd_reg.src, hs_reg[mste_pkg::POS_W-1:0]};
                    mem_wd = cmd_reg.item;
                end
            end
            mste_pkg::ST_COPY: begin
                mem_re = (idx_reg != n_reg);
                mem_we = (idx_reg != '0);
            end
            mste_pkg::ST_WR_HS: begin
                hgt_we    = 1'b1;
                hgt_idx   = cmd_reg.src;
                hgt_wdata = hs_new_reg;
            end
            mste_pkg::ST_WR_HD: begin
                hgt_we    = 1'b1;
                hgt_idx   = cmd_reg.dst;
                hgt_wdata = hd_new_reg;
            end
            mste_pkg::ST_TOP_S: begin
                mem_re = (hs_new_reg != '0);
                mem_ra = {cmd_reg.src, mste_pkg::POS_W'(hs_new_reg - mste_pkg::HGT_W'(1))};
            end
            mste_pkg::ST_TOP_D: begin
                mem_re = (hd_new_reg != '0);
                mem_ra = {cmd_reg.dst, mste_pkg::POS_W'(hd_new_reg - mste_pkg::HGT_W'(1))};
            end
            mste_pkg::ST_DONE: begin
                res_load = !m_valid_reg || m_ready;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < mste_pkg::NUM_STACKS; k++) begin
                height_reg[k] <= '0;
            end
        end else if (hgt_we) begin
            height_reg[hgt_idx] <= hgt_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mste_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            mste_pkg::ST_IDLE: begin
                if (q_valid) begin
                    cmd_reg <= q_cmd;
                end
            end
            mste_pkg::ST_RD_HS: begin
                hs_reg <= hgt_rdata;
            end
            mste_pkg::ST_RD_HD: begin
                hd_reg <= hgt_rdata;
            end
            mste_pkg::ST_PLAN: begin
                idx_reg <= '0;
                if (cmd_reg.kind == mste_pkg::KIND_PUSH) begin
                    n_reg <= '0;
                    if (push_fits) begin
                        hs_new_reg <= hs_reg + mste_pkg::HGT_W'(1);
                        hd_new_reg <= hs_reg + mste_pkg::HGT_W'(1);
                        moved_reg  <= mste_pkg::CNT_W'(1);
                        status_reg <= mste_pkg::STATUS_OK;
                    end else begin
                        hs_new_reg <= hs_reg;
                        hd_new_reg <= hs_reg;
                        moved_reg  <= '0;
                        status_reg <= mste_pkg::STATUS_DST_CLAMP;
                    end
                end else if (is_move) begin
                    n_reg      <= plan_n;
                    hs_new_reg <= hs_reg - plan_n;
                    hd_new_reg <= hd_reg + plan_n;
                    moved_reg  <= mste_pkg::CNT_W'(plan_n);
                    status_reg <= plan_status;
                end else begin
                    n_reg      <= '0;
                    hs_new_reg <= hs_reg;
                    hd_new_reg <= hd_reg;
                    moved_reg  <= '0;
                    status_reg <= mste_pkg::STATUS_OK;
                end
            end
            mste_pkg::ST_COPY: begin
                if (idx_reg != n_reg) begin
                    idx_reg <= idx_reg + mste_pkg::HGT_W'(1);
                end
            end
            mste_pkg::ST_TOP_D: begin
                src_top_reg <= (hs_new_reg == '0) ? '0 : rd_data_reg;
            end
            mste_pkg::ST_DONE: begin
                if (res_load) begin
                    result_reg.moved     <= moved_reg;
                    result_reg.status    <= status_reg;
                    result_reg.src_top   <= src_top_reg;
                    result_reg.src_empty <= (hs_new_reg == '0);
                    result_reg.dst_top   <= (hd_new_reg == '0) ? '0 : rd_data_reg;
                    result_reg.dst_empty <= (hd_new_reg == '0);
                end
            end
            default: begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

    `MSTE_ASSERT_IMPL(a_mem_no_collide, mem_we && mem_re, mem_wa != mem_ra)
    `MSTE_ASSERT_IMPL(a_copy_idx_bound, state_reg == mste_pkg::ST_COPY, idx_reg <= n_reg)
    `MSTE_ASSERT_IMPL(a_height_bound, hgt_we, hgt_wdata <= mste_pkg::HGT_W'(mste_pkg::STACK_DEPTH))
    `MSTE_ASSERT_NEXT(a_load_sets_valid, res_load, m_valid_reg)

endmodule

>>> sv/multi_stack_transfer_engine.sv
// ----------------------------------------------------------------------------
// multi_stack_transfer_engine
// Bank of byte stacks with push, reversing move and order-keeping block move.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_ stream (s_tvalid/s_tready), one command each, and
// every request yields exactly one result on the m_ stream (m_tvalid/m_tready).
// A front stage decodes the request into a two-entry command queue, so up to
// two requests are taken while the execution unit is busy.
// Execution is a fixed sequence of height reads, a plan cycle, height writes
// and two top-of-stack reads, plus a copy phase for a move of n items that
// moves one byte per cycle through the store's separate read and write ports.
// A push or a move of nothing skips the copy phase.
// Reset (aresetn low, synchronous) empties every stack and the queue; store
// contents are not cleared, since bytes above a stack's height are never read.
// When m_tready is low the result is held in the output register; the next
// command still executes and then waits for that register to free up.
// ----------------------------------------------------------------------------
module multi_stack_transfer_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // count [6:0], source_stack [10:7], dest_stack [14:11], item_byte [22:15]
    input  logic [mste_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation [1:0]
    input  logic [mste_pkg::OP_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // moved [6:0], status [8:7], source_top [16:9], source_empty [17],
    // dest_top [25:18], dest_empty [26]
    output logic [mste_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic              q_valid;
    logic              q_pop;
    mste_pkg::cmd_t    q_cmd;
    mste_pkg::result_t result;

    mste_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    mste_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = mste_pkg::M_TDATA_W'(result);

endmodule

>>> verif/tb_multi_stack_transfer_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_stack_transfer_engine
// Self-checking stream testbench for the multi-stack transfer engine. Requests
// go in through the s_ channel, and a behavioral copy of the stack bank
// predicts each result. Results are checked in order on the m_ channel while
// both sides idle in random bursts in the tests that set idle_pct above zero.
// ----------------------------------------------------------------------------
module tb_multi_stack_transfer_engine;

    localparam logic [mste_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam int                        CYCLE_LIMIT = 1000000;
    localparam int                        TAIL_CYCLES = 200;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    // count [6:0], source_stack [10:7], dest_stack [14:11], item_byte [22:15]
    logic [mste_pkg::S_TDATA_W-1:0] s_tdata;
    // operation [1:0]
    logic [mste_pkg::OP_W-1:0]      s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    // moved [6:0], status [8:7], source_top [16:9], source_empty [17],
    // dest_top [25:18], dest_empty [26]
    logic [mste_pkg::M_TDATA_W-1:0] m_tdata;

    // Behavioral copy of the stack bank.
    logic [mste_pkg::BYTE_W-1:0] stack_bytes [mste_pkg::NUM_STACKS][mste_pkg::STACK_DEPTH];
    int                          stack_fill  [mste_pkg::NUM_STACKS];

    mste_pkg::result_t pending_results [$];
    int                error_count = 0;
    int                cycle_count = 0;
    int                idle_pct    = 0;

    multi_stack_transfer_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL multi_stack_transfer_engine");
            $finish;
        end
    end

    function automatic logic [mste_pkg::BYTE_W-1:0] stack_top(input int s);
        if (stack_fill[s] == 0) begin
            return '0;
        end
        return stack_bytes[s][stack_fill[s] - 1];
    endfunction

    // Applies one request to the bank copy and returns the result it yields.
    function automatic mste_pkg::result_t predict_transfer(
            input logic [mste_pkg::OP_W-1:0]   op,
            input logic [mste_pkg::CNT_W-1:0]  cnt,
            input logic [mste_pkg::IDX_W-1:0]  src_f,
            input logic [mste_pkg::IDX_W-1:0]  dst_f,
            input logic [mste_pkg::BYTE_W-1:0] data);
        mste_pkg::result_t r;
        int                src;
        int                dst;
        int                hs;
        int                hd;
        int                n;
        int                from;
        r   = '0;
        src = int'(src_f) % mste_pkg::NUM_STACKS;
        dst = int'(dst_f) % mste_pkg::NUM_STACKS;
        if (op == mste_pkg::OP_PUSH) begin
            dst = src;
            if (stack_fill[src] < mste_pkg::STACK_DEPTH) begin
                stack_bytes[src][stack_fill[src]] = data;
                stack_fill[src]++;
                r.moved = 7'd1;
            end else begin
                r.status = mste_pkg::STATUS_DST_CLAMP;
            end
        end else if ((op == mste_pkg::OP_MOVE_REV || op == mste_pkg::OP_MOVE_BLK)
                     && src != dst) begin
            hs = stack_fill[src];
            hd = stack_fill[dst];
            n  = int'(cnt);
            if (n > hs) begin
                n        = hs;
                r.status = mste_pkg::STATUS_SRC_CLAMP;
            end
            if (n > mste_pkg::STACK_DEPTH - hd) begin
                n        = mste_pkg::STACK_DEPTH - hd;
                r.status = mste_pkg::STATUS_DST_CLAMP;
            end
            for (int i = 0; i < n; i++) begin
                // Popping one at a time reverses; the block copy keeps order.
                from = (op == mste_pkg::OP_MOVE_REV) ? hs - 1 - i : hs - n + i;
                stack_bytes[dst][hd + i] = stack_bytes[src][from];
            end
            stack_fill[src] = hs - n;
            stack_fill[dst] = hd + n;
            r.moved = mste_pkg::CNT_W'(n);
        end
        r.src_top   = stack_top(src);
        r.src_empty = (stack_fill[src] == 0);
        r.dst_top   = stack_top(dst);
        r.dst_empty = (stack_fill[dst] == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        mste_pkg::result_t seen;
        mste_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = mste_pkg::result_t'(m_tdata[$bits(mste_pkg::result_t)-1:0]);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", int'(seen), 0);
            end else begin
                want = pending_results.pop_front();
                if (seen.moved !== want.moved)
                    report_mismatch("moved", int'(seen.moved), int'(want.moved));
                if (seen.status !== want.status)
                    report_mismatch("status", int'(seen.status), int'(want.status));
                if (seen.src_top !== want.src_top)
                    report_mismatch("source_top", int'(seen.src_top), int'(want.src_top));
                if (seen.src_empty !== want.src_empty)
                    report_mismatch("source_empty", int'(seen.src_empty),
                                    int'(want.src_empty));
                if (seen.dst_top !== want.dst_top)
                    report_mismatch("dest_top", int'(seen.dst_top), int'(want.dst_top));
                if (seen.dst_empty !== want.dst_empty)
                    report_mismatch("dest_empty", int'(seen.dst_empty),
                                    int'(want.dst_empty));
            end
        end
    end

    // Result side back-pressure in random bursts.
    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 2) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // Called at a falling edge. On return s_tvalid is still high with the old
    // request, so the caller either sends again at once or drops the valid.
    task automatic send_request(input logic [mste_pkg::OP_W-1:0]   op,
                                input logic [mste_pkg::CNT_W-1:0]  cnt,
                                input logic [mste_pkg::IDX_W-1:0]  src,
                                input logic [mste_pkg::IDX_W-1:0]  dst,
                                input logic [mste_pkg::BYTE_W-1:0] data);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, data, dst, src, cnt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.insert(pending_results.size(),
                               predict_transfer(op, cnt, src, dst, data));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic send_random_request(input int push_pct, input int lo, input int hi);
        logic [mste_pkg::OP_W-1:0]  op;
        logic [mste_pkg::CNT_W-1:0] cnt;
        int                         pick;
        pick = $urandom_range(0, 99);
        if (pick < push_pct) begin
            op = mste_pkg::OP_PUSH;
        end else if (pick >= 97) begin
            op = OP_UNUSED;
        end else begin
            op = $urandom_range(0, 1) ? mste_pkg::OP_MOVE_REV : mste_pkg::OP_MOVE_BLK;
        end
        // Mostly short moves; a few full-depth and over-range counts.
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            cnt = mste_pkg::CNT_W'($urandom_range(0, 8));
        end else if (pick < 9) begin
            cnt = mste_pkg::CNT_W'($urandom_range(0, mste_pkg::STACK_DEPTH));
        end else begin
            cnt = mste_pkg::CNT_W'($urandom_range(0, 127));
        end
        send_request(op, cnt,
                     mste_pkg::IDX_W'($urandom_range(lo, hi)),
                     mste_pkg::IDX_W'($urandom_range(lo, hi)),
                     mste_pkg::BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic test_directed();
        idle_pct = 10;
        send_request(mste_pkg::OP_PUSH, 7'd0, 4'd0, 4'd9, 8'h00);
        send_request(mste_pkg::OP_PUSH, 7'd127, 4'd15, 4'd0, 8'hFF);
        send_request(mste_pkg::OP_PUSH, 7'd0, 4'd1, 4'd1, 8'hA5);
        send_request(mste_pkg::OP_PUSH, 7'd0, 4'd1, 4'd1, 8'h5A);
        send_request(mste_pkg::OP_PUSH, 7'd0, 4'd1, 4'd1, 8'h3C);
        send_request(mste_pkg::OP_PUSH, 7'd0, 4'd1, 4'd1, 8'h81);
        send_request(mste_pkg::OP_MOVE_REV, 7'd2, 4'd1, 4'd2, 8'h00);
        send_request(mste_pkg::OP_MOVE_BLK, 7'd2, 4'd1, 4'd3, 8'h00);
        send_request(mste_pkg::OP_MOVE_BLK, 7'd0, 4'd15, 4'd0, 8'h00);
        // Count beyond the source height is clamped to it.
        send_request(mste_pkg::OP_MOVE_REV, 7'd127, 4'd15, 4'd0, 8'h00);
        send_request(mste_pkg::OP_MOVE_BLK, 7'd64, 4'd2, 4'd15, 8'h00);
        send_request(mste_pkg::OP_MOVE_REV, 7'd1, 4'd3, 4'd3, 8'h00);
        send_request(mste_pkg::OP_MOVE_BLK, 7'd2, 4'd3, 4'd3, 8'h00);
        send_request(OP_UNUSED, 7'd3, 4'd3, 4'd15, 8'h12);
        send_request(mste_pkg::OP_MOVE_BLK, 7'd5, 4'd7, 4'd8, 8'h00);
        send_request(mste_pkg::OP_MOVE_REV, 7'd5, 4'd7, 4'd8, 8'h00);
        send_request(OP_UNUSED, 7'd127, 4'd15, 4'd15, 8'hFF);
        send_request(mste_pkg::OP_MOVE_BLK, 7'd3, 4'd15, 4'd0, 8'h00);
        send_request(mste_pkg::OP_MOVE_REV, 7'd3, 4'd0, 4'd14, 8'h00);
    endtask

    task automatic test_random_mix(input int n, input int idle);
        idle_pct = idle;
        repeat (n) send_random_request(45, 0, mste_pkg::NUM_STACKS - 1);
    endtask

    // Pushes on two stacks fill them, so moves between them hit the
    // destination limit and further pushes meet a full stack.
    task automatic test_full_stacks(input int n);
        idle_pct = 0;
        repeat (n) send_random_request(65, 10, 11);
    endtask

    task automatic test_drain_pause();
        wait_drained();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        for (int s = 0; s < mste_pkg::NUM_STACKS; s++) begin
            stack_fill[s] = 0;
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_random_mix(330, 30);
        test_full_stacks(240);
        test_drain_pause();
        test_random_mix(120, 60);
        test_random_mix(220, 0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS multi_stack_transfer_engine");
        end else begin
            $display("FAIL multi_stack_transfer_engine");
        end
        $finish;
    end

endmodule
